>>> hw/rtl/gha_pkg.sv
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types, constants and field arithmetic for the GHASH accumulator.
// ----------------------------------------------------------------------------
package gha_pkg;

   // block geometry
   localparam int BLOCK_BYTES = 16;
   localparam int BLOCK_W     = 8 * BLOCK_BYTES;
   localparam int COUNT_W     = 61;
   localparam int DIGIT_W     = 8;
   localparam int DIGITS      = BLOCK_W / DIGIT_W;
   localparam int CNT_W       = $clog2(DIGITS);

   localparam logic [CNT_W-1:0] DIGIT_LAST = CNT_W'(DIGITS - 1);
   localparam logic [4:0]       BYTES_FULL = 5'(BLOCK_BYTES);

   // top byte of the reduction term for x^128 + x^7 + x^2 + x + 1
   localparam logic [7:0] GF_POLY = 8'hE1;

   // configuration register indexes
   localparam logic [1:0] CSR_KEY_HIGH = 2'd0;
   localparam logic [1:0] CSR_KEY_LOW  = 2'd1;

   // input item
   typedef struct packed {
      logic [63:0] block_high;
      logic [63:0] block_low;
      logic [4:0]  valid_bytes;
      logic        is_text;
      logic        last;
   } gha_req_type;

   // result item
   typedef struct packed {
      logic [63:0] tag_high;
      logic [63:0] tag_low;
   } gha_rsp_type;

   // command passed from the front end to the multiplier
   typedef struct packed {
      logic [BLOCK_W-1:0] blk;
      logic [BLOCK_W-1:0] len;
      logic               has_data;
      logic               last;
   } gha_cmd_type;

   // queue status
   typedef struct packed {
      logic full;
      logic empty;
   } gha_qstat_type;

   // multiplier sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DATA,
      ST_LEN,
      ST_OUT
   } gha_state_type;

   // multiply by x in gcm bit order (bit 127 is the x^0 coefficient)
   function automatic logic [BLOCK_W-1:0] gf_mul_x(input logic [BLOCK_W-1:0] w);
      logic [BLOCK_W-1:0] r;
      r = w >> 1;
      if (w[0]) begin
         r[BLOCK_W-1 -: 8] = r[BLOCK_W-1 -: 8] ^ GF_POLY;
      end
      return r;
   endfunction

   // one horner step: z * x^8 + digit * h, digit bit 7 is the lowest power
   function automatic logic [BLOCK_W-1:0] gf_digit_step(
      input logic [BLOCK_W-1:0] z,
      input logic [BLOCK_W-1:0] h,
      input logic [DIGIT_W-1:0] d
   );
      logic [BLOCK_W-1:0] r;
      logic [BLOCK_W-1:0] hx;
      r  = z;
      hx = h;
      for (int i = 0; i < DIGIT_W; i++) begin
         r = gf_mul_x(r);
      end
      for (int j = 0; j < DIGIT_W; j++) begin
         if (d[DIGIT_W-1-j]) begin
            r = r ^ hx;
         end
         hx = gf_mul_x(hx);
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/gha_front.sv
// ----------------------------------------------------------------------------
// gha_front
// Accepts items, masks unused bytes, keeps the byte counts and builds the
// length block, then queues a command for the multiplier.
// ----------------------------------------------------------------------------
module gha_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  gha_pkg::gha_req_type   req_data,
   input  gha_pkg::gha_qstat_type q_stat,
   output logic                   push_valid,
   output gha_pkg::gha_cmd_type   push_cmd
);
   import gha_pkg::*;

   logic [COUNT_W-1:0] aad_ff, aad_in;
   logic [COUNT_W-1:0] text_ff, text_in;
   logic               accept;
   logic [4:0]         nbytes;
   logic               has_data;
   logic [BLOCK_W-1:0] mask;
   logic [COUNT_W-1:0] aad_sum, text_sum;

   assign req_stall = q_stat.full;
   assign accept    = req_valid && !q_stat.full;

   // clamp the byte count and build the byte mask
   always_comb begin
      nbytes   = (req_data.valid_bytes > BYTES_FULL) ? BYTES_FULL : req_data.valid_bytes;
      has_data = (nbytes != 5'd0);
      for (int k = 0; k < BLOCK_BYTES; k++) begin
         mask[BLOCK_W-1-8*k -: 8] = (5'(k) < nbytes) ? 8'hFF : 8'h00;
      end
   end

   // running counts including this item
   always_comb begin
      aad_sum  = aad_ff;
      text_sum = text_ff;
      if (has_data && req_data.is_text) begin
         text_sum = text_ff + COUNT_W'(nbytes);
      end else if (has_data) begin
         aad_sum = aad_ff + COUNT_W'(nbytes);
      end
   end

   // counts clear after a last item
   always_comb begin
      aad_in  = aad_ff;
      text_in = text_ff;
      if (accept) begin
         aad_in  = req_data.last ? '0 : aad_sum;
         text_in = req_data.last ? '0 : text_sum;
      end
   end

   // command toward the queue; empty items that are not last are dropped
   always_comb begin
      push_valid        = accept && (has_data || req_data.last);
      push_cmd.blk      = {req_data.block_high, req_data.block_low} & mask;
      push_cmd.len      = {aad_sum, 3'b000, text_sum, 3'b000};
      push_cmd.has_data = has_data;
      push_cmd.last     = req_data.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         aad_ff  <= '0;
         text_ff <= '0;
      end else begin
         aad_ff  <= aad_in;
         text_ff <= text_in;
      end
   end

endmodule

>>> hw/rtl/gha_queue.sv
// ----------------------------------------------------------------------------
// gha_queue
// Small command queue between the front end and the multiplier.
// ----------------------------------------------------------------------------
module gha_queue #(
   parameter int DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  gha_pkg::gha_cmd_type   push_cmd,
   input  logic                   pop,
   output gha_pkg::gha_cmd_type   head,
   output gha_pkg::gha_qstat_type q_stat
);
   import gha_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(DEPTH);

   gha_cmd_type         entry_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic                do_push, do_pop;

   assign q_stat.full  = (fill_ff == FILL_MAX);
   assign q_stat.empty = (fill_ff == '0);
   assign head         = entry_ff[rd_ptr_ff];
   assign do_push      = push_valid && !q_stat.full;
   assign do_pop       = pop && !q_stat.empty;

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> hw/rtl/gha_back.sv
// ----------------------------------------------------------------------------
// gha_back
// Digit-serial GF(2^128) multiplier with the accumulator and the result
// register. One 8-bit digit of the operand is folded in per cycle.
// ----------------------------------------------------------------------------
module gha_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [gha_pkg::BLOCK_W-1:0] key,
   input  gha_pkg::gha_qstat_type      q_stat,
   input  gha_pkg::gha_cmd_type        head,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output gha_pkg::gha_rsp_type        rsp_data
);
   import gha_pkg::*;

   gha_state_type      state_ff, state_in;
   logic [BLOCK_W-1:0] acc_ff, acc_in;
   logic [BLOCK_W-1:0] op_ff, op_in;
   logic [BLOCK_W-1:0] len_ff, len_in;
   logic               last_ff, last_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   gha_rsp_type        rsp_data_ff, rsp_data_in;
   logic [BLOCK_W-1:0] step;
   logic               out_free;

   assign step      = gf_digit_step(acc_ff, key, op_ff[DIGIT_W-1:0]);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               state_in = head.has_data ? ST_DATA : ST_LEN;
            end
         end
         ST_DATA: begin
            if (cnt_ff == DIGIT_LAST) begin
               state_in = last_ff ? ST_LEN : ST_IDLE;
            end
         end
         ST_LEN: begin
            if (cnt_ff == DIGIT_LAST) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      acc_in       = acc_ff;
      op_in        = op_ff;
      len_in       = len_ff;
      last_in      = last_ff;
      cnt_in       = cnt_ff;
      pop          = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               pop     = 1'b1;
               len_in  = head.len;
               last_in = head.last;
               cnt_in  = '0;
               acc_in  = '0;
               op_in   = acc_ff ^ (head.has_data ? head.blk : head.len);
            end
         end
         ST_DATA: begin
            acc_in = step;
            op_in  = op_ff >> DIGIT_W;
            cnt_in = cnt_ff + 1'b1;
            // fold the length block straight into the next product
            if (cnt_ff == DIGIT_LAST && last_ff) begin
               op_in  = step ^ len_ff;
               acc_in = '0;
            end
         end
         ST_LEN: begin
            acc_in = step;
            op_in  = op_ff >> DIGIT_W;
            cnt_in = cnt_ff + 1'b1;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.tag_high = acc_ff[BLOCK_W-1 -: 64];
               rsp_data_in.tag_low  = acc_ff[63:0];
               acc_in               = '0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         last_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         last_ff      <= last_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      len_ff      <= len_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> hw/rtl/ghash_accumulator_unit.sv
// ----------------------------------------------------------------------------
// ghash_accumulator_unit
// GCM GHASH engine: hashes 16-byte blocks under key H and emits the tag.
// ----------------------------------------------------------------------------
// In the multiplier, each item with data takes an operand load and the
// digit-serial GF(2^128) multiply, which folds one 8-bit digit per cycle.
// A last item adds a length block multiply and a tag load into the result
// register, which waits while a result is stalled; a last item with no data
// takes only the load, the length multiply and the tag load. Items with no
// data that are not last are absorbed by the front end, which accepts items
// into a QUEUE_DEPTH command queue while the multiplier works, so the
// sustained rate is set by the multiplier. The user must write the key
// through the csr port only while the engine is idle; it is not enforced.
module ghash_accumulator_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  gha_pkg::gha_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output gha_pkg::gha_rsp_type rsp_data,
   input  logic                 csr_write_en,
   input  logic [1:0]           csr_index,
   input  logic [63:0]          csr_write_data
);
   import gha_pkg::*;

   logic [63:0]   key_high_ff, key_high_in;
   logic [63:0]   key_low_ff, key_low_in;
   gha_qstat_type q_stat;
   gha_cmd_type   push_cmd, head;
   logic          push_valid, pop;

   // key register decode
   always_comb begin
      key_high_in = key_high_ff;
      key_low_in  = key_low_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_KEY_HIGH: key_high_in = csr_write_data;
            CSR_KEY_LOW:  key_low_in  = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else begin
         key_high_ff <= key_high_in;
         key_low_ff  <= key_low_in;
      end
   end

   // item intake and byte counts
   gha_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .q_stat     (q_stat),
      .push_valid (push_valid),
      .push_cmd   (push_cmd)
   );

   // command queue
   gha_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .head       (head),
      .q_stat     (q_stat)
   );

   // multiplier and result register
   gha_back u_back (
      .clock     (clock),
      .reset     (reset),
      .key       ({key_high_ff, key_low_ff}),
      .q_stat    (q_stat),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> hw/rtl/gha_chk.sv
// ----------------------------------------------------------------------------
// gha_chk
// Port-level checks for the GHASH accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module gha_chk (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input gha_pkg::gha_rsp_type rsp_data
);
   import gha_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   // reset empties the result register
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // reset empties the queue so items are taken at once
   a_req_reset: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("intake stalled right after reset");

   // a tag does not rise when reset was high a full multiply earlier
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(reset, DIGITS))
      else $error("tag appeared too soon after reset");

endmodule

bind ghash_accumulator_unit gha_chk u_chk (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
